FILE: rtl/core/bump_and_bitmap_slot_allocator_macros.svh
// Assertion macros used by the checker file of the slot allocator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BUMP_AND_BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BUMP_AND_BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bbsa_pkg.sv
// Shared constants, codes and types of the bump and bitmap slot allocator.
// No dependencies; every other file of the block but the macros header imports this package.
package bbsa_pkg;

    localparam int POOL_SLOTS    = 1024;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = (POOL_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_IDX_W  = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;
    localparam int SLOT_W     = WORD_IDX_W + BIT_IDX_W;
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

    localparam int POOL_SIZE_W  = 11;
    localparam int SLOT_INDEX_W = 10;
    localparam int STATUS_W     = 2;

    localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RESET = 11'd1024;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // One bit update of the used bitmap.
    typedef struct packed {
        logic                  en;
        logic                  set;
        logic [WORD_IDX_W-1:0] word;
        logic [BIT_IDX_W-1:0]  bit_idx;
    } bbsa_wr_t;

endpackage

FILE: rtl/core/bump_and_bitmap_slot_allocator.sv
// Slot allocator: a bump pointer hands out never-used slots first; once it reaches the pool
// size, an allocate walks the used bitmap one 64-bit word per cycle and grants the lowest
// clear slot below the pool size. A free or a bump allocate needs no scan; an allocate
// after exhaustion scans up to 16 words with the single word scanner before its result.
// in_ready is high only while no item is in flight or waiting at the output.
// Depends on bbsa_pkg, bbsa_bitmap and bbsa_scan.
module bump_and_bitmap_slot_allocator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [bbsa_pkg::POOL_SIZE_W-1:0]     cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic [bbsa_pkg::SLOT_INDEX_W-1:0]    slot_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bbsa_pkg::STATUS_W-1:0]        status,
    output logic [bbsa_pkg::SLOT_INDEX_W-1:0]    slot_out
);
    import bbsa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                   state_reg,     state_next;
    logic [POOL_SIZE_W-1:0]   pool_size_reg;
    logic [CNT_W-1:0]         fresh_top_reg, fresh_top_next;
    logic [WORD_IDX_W-1:0]    word_reg,      word_next;
    logic [STATUS_W-1:0]      status_reg,    status_next;
    logic [SLOT_W-1:0]        slot_reg,      slot_next;

    logic [CNT_W-1:0]         limit;
    logic [WORD_IDX_W-1:0]    last_word;
    logic                     in_xfer;
    logic                     fresh_ok;
    logic                     free_ok;
    logic [SLOT_W-1:0]        fresh_slot;
    logic [SLOT_W-1:0]        free_slot;
    logic [SLOT_W-1:0]        scan_slot;
    logic                     hit_ok;
    logic [MAP_WORD_BITS-1:0] map_word;
    logic                     found;
    logic [BIT_IDX_W-1:0]     hit_bit;
    bbsa_wr_t                 wr;

    bbsa_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_word (word_reg),
        .rd_data (map_word)
    );

    bbsa_scan u_scan (
        .word    (map_word),
        .found   (found),
        .bit_idx (hit_bit)
    );

    // A pool size above the bitmap capacity saturates.
    assign limit = (32'(pool_size_reg) > 32'(POOL_SLOTS)) ? CNT_W'(POOL_SLOTS)
                                                          : CNT_W'(pool_size_reg);
    assign last_word  = WORD_IDX_W'((32'(limit) - 32'd1) >> BIT_IDX_W);
    assign in_xfer    = in_valid && in_ready;
    assign fresh_ok   = 32'(fresh_top_reg) < 32'(limit);
    assign free_ok    = 32'(slot_index) < 32'(limit);
    assign fresh_slot = SLOT_W'(fresh_top_reg);
    assign free_slot  = SLOT_W'(slot_index);
    assign scan_slot  = {word_reg, hit_bit};
    assign hit_ok     = found && (32'(scan_slot) < 32'(limit));

    always_comb
    begin
        state_next     = state_reg;
        fresh_top_next = fresh_top_reg;
        word_next      = word_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        wr             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next  = ST_DONE;
                    status_next = STATUS_OK;
                    slot_next   = '0;
                    if (action == ACT_ALLOC)
                    begin
                        if (fresh_ok)
                        begin
                            slot_next      = fresh_slot;
                            fresh_top_next = fresh_top_reg + 1'b1;
                            wr.en          = 1'b1;
                            wr.set         = 1'b1;
                            wr.word        = fresh_slot[SLOT_W-1:BIT_IDX_W];
                            wr.bit_idx     = fresh_slot[BIT_IDX_W-1:0];
                        end
                        else if (limit == '0)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            word_next  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (free_ok)
                    begin
                        wr.en      = 1'b1;
                        wr.set     = 1'b0;
                        wr.word    = free_slot[SLOT_W-1:BIT_IDX_W];
                        wr.bit_idx = free_slot[BIT_IDX_W-1:0];
                    end
                    else
                    begin
                        status_next = STATUS_BAD;
                    end
                end
            end

            ST_SCAN:
            begin
                if (hit_ok)
                begin
                    slot_next   = scan_slot;
                    wr.en       = 1'b1;
                    wr.set      = 1'b1;
                    wr.word     = word_reg;
                    wr.bit_idx  = hit_bit;
                    state_next  = ST_DONE;
                end
                // A clear bit at or above the pool size means nothing lower is free.
                else if (found || (word_reg == last_word))
                begin
                    status_next = STATUS_FULL;
                    state_next  = ST_DONE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pool_size_reg <= POOL_SIZE_RESET;
            fresh_top_reg <= '0;
            word_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_top_reg <= fresh_top_next;
            word_reg      <= word_next;
            if (cfg_write_en)
            begin
                pool_size_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign status    = status_reg;
    assign slot_out  = SLOT_INDEX_W'(slot_reg);

endmodule

FILE: rtl/core/bbsa_scan.sv
// Finder of the lowest clear bit in one bitmap word.
// Depends on bbsa_pkg for the word and bit index widths.
module bbsa_scan (
    input  logic [bbsa_pkg::MAP_WORD_BITS-1:0] word,
    output logic                               found,
    output logic [bbsa_pkg::BIT_IDX_W-1:0]     bit_idx
);
    import bbsa_pkg::*;

    logic [MAP_WORD_BITS-1:0] lowest;

    // Adding one to the word ripples through its low run of ones and lands on
    // the lowest clear bit, so this leaves exactly that bit set.
    always_comb
    begin
        lowest  = ~word & (word + 1'b1);
        found   = |(~word);
        bit_idx = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                bit_idx = bit_idx | BIT_IDX_W'(i);
            end
        end
    end

endmodule

FILE: rtl/core/bbsa_bitmap.sv
// Used bitmap of the slot pool, one flip-flop per slot, cleared by reset.
// Depends on bbsa_pkg for its geometry and the update struct.
module bbsa_bitmap (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bbsa_pkg::bbsa_wr_t                 wr,
    input  logic [bbsa_pkg::WORD_IDX_W-1:0]    rd_word,
    output logic [bbsa_pkg::MAP_WORD_BITS-1:0] rd_data
);
    import bbsa_pkg::*;

    logic [MAP_WORD_BITS-1:0] map_reg [MAP_WORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
            begin
                if (wr.word == WORD_IDX_W'(i))
                begin
                    map_reg[i][wr.bit_idx] <= wr.set;
                end
            end
        end
    end

    assign rd_data = map_reg[rd_word];

endmodule

FILE: rtl/core/bbsa_chk.sv
// Port-level checker of the slot allocator, bound to the top level below.
// Depends on bbsa_pkg and the assertion macros header.
`include "bump_and_bitmap_slot_allocator_macros.svh"

module bbsa_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [bbsa_pkg::STATUS_W-1:0]     status,
    input logic [bbsa_pkg::SLOT_INDEX_W-1:0] slot_out
);
    import bbsa_pkg::*;

    // Only one item is in flight, so a waiting result blocks new input.
    `BBSA_ASSERT_SAME(a_result_blocks_input, out_valid, !in_ready, "input taken while result waits")

    `BBSA_ASSERT_NEXT(a_busy_after_input, in_valid && in_ready, !in_ready, "two items accepted")

    // Each transfer in gives exactly one result.
    `BBSA_ASSERT_NEXT(a_single_result, out_valid && out_ready, !out_valid, "result repeated")

    `BBSA_ASSERT_SAME(a_slot_zero_on_fail, out_valid && (status != STATUS_OK), slot_out == '0,
        "nonzero slot on failure")

endmodule

bind bump_and_bitmap_slot_allocator bbsa_chk u_bbsa_chk (.*);

FILE: tb/sv/bump_and_bitmap_slot_allocator_test.sv
// Self-checking testbench for the bump and bitmap slot allocator.
// It predicts every status and granted slot in its own copy of the pool state.
// Depends on bbsa_pkg and the bump_and_bitmap_slot_allocator RTL.
`timescale 1ns / 1ps

module bump_and_bitmap_slot_allocator_test;

    import bbsa_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_PRINTED = 200;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic                    act;
        logic [SLOT_INDEX_W-1:0] idx;
    } slot_req_t;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_INDEX_W-1:0] slot;
    } slot_grant_t;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    cfg_write_en   = 1'b0;
    logic [POOL_SIZE_W-1:0]  cfg_write_data = '0;
    logic                    in_valid       = 1'b0;
    logic                    in_ready;
    logic                    action         = ACT_ALLOC;
    logic [SLOT_INDEX_W-1:0] slot_index     = '0;
    logic                    out_valid;
    logic                    out_ready      = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_INDEX_W-1:0] slot_out;

    slot_req_t   pending_reqs[$];
    slot_grant_t expected_grants[$];
    slot_req_t   next_req;

    // Shadow of the allocator state.
    logic [POOL_SIZE_W-1:0]   shadow_pool_size = POOL_SIZE_RESET;
    int                       shadow_fresh_top = 0;
    logic [MAP_WORD_BITS-1:0] shadow_used [MAP_WORDS];

    idle_mode_t idle_mode   = IDLE_NONE;
    bit         pressure_on = 1'b0;
    bit         hold_done   = 1'b0;
    int         hold_left   = 0;
    logic       in_fire     = 1'b0;
    int         quiet_cycles = 0;

    int error_count  = 0;
    int alloc_count  = 0;
    int free_count   = 0;
    int ok_count     = 0;
    int full_count   = 0;
    int bad_count    = 0;
    int scan_grants  = 0;
    int phases_run   = 0;

    bump_and_bitmap_slot_allocator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .slot_index     (slot_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot_out       (slot_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            shadow_used[w] = '0;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    function automatic bit slot_is_used(input int s);
        return shadow_used[s / MAP_WORD_BITS][s % MAP_WORD_BITS];
    endfunction

    task automatic mark_slot(input int s, input bit on);
        shadow_used[s / MAP_WORD_BITS][s % MAP_WORD_BITS] = on;
    endtask

    // Works out the grant for one request and updates the shadow state.
    task automatic predict_grant(input slot_req_t req);
        slot_grant_t g;
        int          limit;
        bit          found;
        limit    = (shadow_pool_size > POOL_SLOTS) ? POOL_SLOTS : int'(shadow_pool_size);
        g.status = STATUS_OK;
        g.slot   = '0;
        if (req.act == ACT_ALLOC)
        begin
            alloc_count++;
            if (shadow_fresh_top < limit)
            begin
                g.slot = shadow_fresh_top[SLOT_INDEX_W-1:0];
                mark_slot(shadow_fresh_top, 1'b1);
                shadow_fresh_top++;
            end
            else
            begin
                // Pool exhausted: the lowest clear slot below the limit wins.
                found = 1'b0;
                for (int s = 0; s < limit && !found; s++)
                begin
                    if (!slot_is_used(s))
                    begin
                        found  = 1'b1;
                        g.slot = s[SLOT_INDEX_W-1:0];
                        mark_slot(s, 1'b1);
                    end
                end
                if (found)
                begin
                    scan_grants++;
                end
                else
                begin
                    g.status = STATUS_FULL;
                end
            end
        end
        else
        begin
            free_count++;
            if (int'(req.idx) < limit)
            begin
                mark_slot(int'(req.idx), 1'b0);
            end
            else
            begin
                g.status = STATUS_BAD;
            end
        end
        expected_grants.push_back(g);
    endtask

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 88;
            IDLE_BOTH:   return $urandom_range(0, 99) < 9;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 88;
            IDLE_BOTH:     return $urandom_range(0, 99) < 9;
            default:       return 1'b0;
        endcase
    endfunction

    // Request driver: a payload is held until its transfer has been seen.
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !in_fire))
        begin
            in_valid <= in_valid && rst_n;
        end
        else if (pending_reqs.size() > 0 && !sender_idles())
        begin
            next_req   = pending_reqs.pop_front();
            in_valid   <= 1'b1;
            action     <= next_req.act;
            slot_index <= next_req.idx;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Grant receiver, with one long hold-off to back the block up.
    always @(negedge clk)
    begin
        if (pressure_on && !hold_done)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && !receiver_stalls();
        end
    end

    // Monitor: checks grants first, then predicts newly accepted requests.
    always @(posedge clk)
    begin
        slot_grant_t want;
        slot_req_t   req;
        in_fire <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            if (expected_grants.size() == 0)
            begin
                report_mismatch("unexpected grant, status", int'(status), -1);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (status != want.status)
                begin
                    report_mismatch("status", int'(status), int'(want.status));
                end
                if (slot_out != want.slot)
                begin
                    report_mismatch("slot_out", int'(slot_out), int'(want.slot));
                end
                case (want.status)
                    STATUS_OK:   ok_count++;
                    STATUS_FULL: full_count++;
                    default:     bad_count++;
                endcase
            end
        end
        if (in_valid && in_ready)
        begin
            req.act = action;
            req.idx = slot_index;
            predict_grant(req);
        end
        if (cfg_write_en)
        begin
            shadow_pool_size = cfg_write_data;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_pool(input int pool);
        wait_idle();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= pool[POOL_SIZE_W-1:0];
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_req(input logic act, input int idx);
        slot_req_t req;
        req.act = act;
        req.idx = idx[SLOT_INDEX_W-1:0];
        pending_reqs.push_back(req);
    endtask

    task automatic run_phase(input int pool, input idle_mode_t mode, input int count,
                             input int alloc_pct, input bit squeeze);
        int limit;
        set_pool(pool);
        limit       = (pool > POOL_SLOTS) ? POOL_SLOTS : pool;
        idle_mode   = mode;
        pressure_on = squeeze;
        for (int i = 0; i < count; i++)
        begin
            if (limit > 0 && $urandom_range(0, 99) < 85)
            begin
                push_req(($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE,
                         $urandom_range(0, limit - 1));
            end
            else
            begin
                push_req(($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE,
                         $urandom_range(0, 1023));
            end
        end
        phases_run++;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset pool size: bump grants and frees at both ends.
        push_req(ACT_ALLOC, 0);
        push_req(ACT_ALLOC, 1023);
        push_req(ACT_ALLOC, 0);
        push_req(ACT_FREE, 1);
        push_req(ACT_FREE, 1023);
        push_req(ACT_ALLOC, 0);
        push_req(ACT_FREE, 0);
        // An empty pool refuses everything.
        set_pool(0);
        push_req(ACT_ALLOC, 0);
        push_req(ACT_FREE, 0);
        push_req(ACT_FREE, 1023);
        // An oversized pool saturates at the full slot count.
        set_pool(2047);
        push_req(ACT_FREE, 1023);
        push_req(ACT_ALLOC, 0);
        // A pool below the bump pointer forces bitmap scans.
        set_pool(3);
        push_req(ACT_ALLOC, 0);
        push_req(ACT_ALLOC, 0);
        push_req(ACT_FREE, 5);
        push_req(ACT_FREE, 2);
        push_req(ACT_ALLOC, 0);
        set_pool(1);
        push_req(ACT_ALLOC, 0);
        push_req(ACT_FREE, 0);
        push_req(ACT_ALLOC, 0);
        phases_run = 5;

        run_phase(16, IDLE_NONE, 120, 60, 1'b0);
        // Exhaust the bump pointer over the whole pool so later scans go deep.
        run_phase(1024, IDLE_BOTH, 1100, 95, 1'b0);
        run_phase(1024, IDLE_SENDER, 150, 50, 1'b0);
        run_phase(1024, IDLE_RECEIVER, 100, 50, 1'b1);
        run_phase($urandom_range(1, 200), IDLE_BOTH, 120, 65, 1'b0);
        run_phase(0, IDLE_NONE, 20, 50, 1'b0);
        run_phase($urandom_range(1, 64), IDLE_SENDER, 100, 70, 1'b0);
        run_phase(2047, IDLE_RECEIVER, 100, 50, 1'b0);
        run_phase($urandom_range(1025, 2047), IDLE_NONE, 80, 55, 1'b0);
        run_phase($urandom_range(1, 1024), IDLE_BOTH, 100, 60, 1'b0);
        run_phase(1, IDLE_NONE, 30, 50, 1'b0);
        run_phase(65, IDLE_RECEIVER, 80, 60, 1'b0);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_grants.size() != 0)
        begin
            report_mismatch("grants still outstanding", expected_grants.size(), 0);
        end

        $display("Ran %0d requests (%0d allocate, %0d free) over %0d pool settings.",
                 alloc_count + free_count, alloc_count, free_count, phases_run);
        $display("Grants seen: %0d ok (%0d from bitmap scans), %0d pool full, %0d bad index.",
                 ok_count, scan_grants, full_count, bad_count);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
